### hdl/dmd_pkg.sv
// Shared types, constants and helper functions of the dual motor drive controller.
package dmd_pkg;

  typedef enum logic [2:0] {
    CMD_TICK     = 3'd0,
    CMD_UPDATE   = 3'd1,
    CMD_JOYSTICK = 3'd2,
    CMD_SET_LEFT = 3'd3,
    CMD_SET_RIGHT = 3'd4,
    CMD_FIRE     = 3'd5,
    CMD_BEEP     = 3'd6
  } cmd_e;

  typedef enum logic [1:0] {
    CFG_FILTER_COEF  = 2'd0,
    CFG_LINK_TIMEOUT = 2'd1,
    CFG_WATCH_ENABLE = 2'd2,
    CFG_PWM_MAX      = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    cmd_e              command;
    logic signed [7:0] speed_or_x;
    logic signed [7:0] joystick_y;
    logic [15:0]       duration_ms;
  } item_t;

  localparam int CH_LEFT   = 0;
  localparam int CH_RIGHT  = 1;
  localparam int CH_CANNON = 2;
  localparam int NUM_CH    = 3;

  localparam int LV_LF     = 0;
  localparam int LV_LR     = 1;
  localparam int LV_RF     = 2;
  localparam int LV_RR     = 3;
  localparam int LV_CAN    = 4;
  localparam int LV_BUZ    = 5;
  localparam int LV_BRIDGE = 6;
  localparam int NUM_LV    = 7;

  localparam logic signed [9:0] SPEED_MAX_W = 10'sd100;
  localparam logic signed [9:0] SPEED_MIN_W = -10'sd100;
  localparam logic signed [7:0] SPEED_FULL  = 8'sd100;
  localparam logic [7:0]        LEVEL_FULL  = 8'd100;

  function automatic logic [6:0] lvl_clamp(input logic [7:0] mag, input logic [6:0] pwm_max);
    logic [6:0] res;
    if (mag > {1'b0, pwm_max}) begin
      res = pwm_max;
    end else begin
      res = mag[6:0];
    end
    return res;
  endfunction

  function automatic logic signed [7:0] sat_speed(input logic signed [9:0] v);
    logic signed [7:0] res;
    if (v > SPEED_MAX_W) begin
      res = SPEED_FULL;
    end else if (v < SPEED_MIN_W) begin
      res = -SPEED_FULL;
    end else begin
      res = v[7:0];
    end
    return res;
  endfunction

endpackage

### hdl/dmd_in_reg.sv
// Input register stage that holds one command until the core processes it.
module dmd_in_reg (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           ready_o,
  input  dmd_pkg::item_t item_i,
  input  logic           advance_i,
  output logic           valid_o,
  output dmd_pkg::item_t item_o
);
  import dmd_pkg::*;

  logic  valid_q;
  logic  valid_d;
  item_t item_q;

  assign ready_o = !valid_q || advance_i;
  assign valid_d = (valid_i && ready_o) ? 1'b1 : (advance_i ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

### hdl/dmd_iir.sv
// One low-pass filter channel with the split positive and negative PWM levels.
module dmd_iir #(
  parameter int FILTER_FRAC_BITS = 8
) (
  input  logic signed [7:0]                  target_i,
  input  logic signed [FILTER_FRAC_BITS+7:0] filt_i,
  input  logic [8:0]                         coef_i,
  input  logic [6:0]                         pwm_max_i,
  output logic signed [FILTER_FRAC_BITS+7:0] filt_o,
  output logic [6:0]                         pos_lvl_o,
  output logic [6:0]                         neg_lvl_o
);
  import dmd_pkg::*;

  localparam int F  = FILTER_FRAC_BITS;
  localparam int CW = (F + 1 > 9) ? F + 1 : 9;
  localparam int SW = F + CW + 10;
  localparam logic [CW-1:0] ONE_Q = CW'(1) << F;

  logic [CW-1:0]         coef_ext;
  logic [CW-1:0]         c;
  logic [CW-1:0]         om;
  logic signed [CW:0]    c_s;
  logic signed [CW:0]    om_s;
  logic signed [CW+8:0]  p_new;
  logic signed [F+CW+8:0] p_old;
  logic signed [SW-1:0]  sum;
  logic signed [SW-1:0]  sum_sh;
  logic signed [F+8:0]   fx;
  logic [F+8:0]          mag;
  logic [7:0]            ip_pos;
  logic [7:0]            ip_neg;

  assign coef_ext = CW'(coef_i);
  assign c        = (coef_ext > ONE_Q) ? ONE_Q : coef_ext;
  assign om       = ONE_Q - c;
  assign c_s      = $signed({1'b0, c});
  assign om_s     = $signed({1'b0, om});
  assign p_new    = target_i * c_s;
  assign p_old    = filt_i * om_s;
  assign sum      = (SW'(p_new) <<< F) + SW'(p_old);
  assign sum_sh   = sum >>> F;
  assign filt_o   = sum_sh[F+7:0];

  assign fx     = (F + 9)'(filt_o);
  assign mag    = -fx;
  assign ip_pos = filt_o[F+7] ? 8'd0 : filt_o[F+7:F];
  assign ip_neg = filt_o[F+7] ? mag[F+7:F] : 8'd0;

  assign pos_lvl_o = lvl_clamp(ip_pos, pwm_max_i);
  assign neg_lvl_o = lvl_clamp(ip_neg, pwm_max_i);

endmodule

### hdl/dual_motor_drive_controller.sv
// Top level of the dual motor drive controller: command state, watchdog and output register.
// Each command transaction on the slave side yields exactly one result transaction with all
// seven held PWM levels and the link flag. A command is held in the input register, then takes
// the single pass of state update and filter logic into the held levels; one command is taken
// every cycle while the master side keeps tready high. The held levels themselves form the
// output register; a stall on the master side holds the pipeline.
// Configuration writes are always ready and must only occur while no command is in flight.
module dual_motor_drive_controller #(
  parameter int TIME_WIDTH       = 32,
  parameter int FILTER_FRAC_BITS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // speed_or_x [7:0], joystick_y [15:8], duration_ms [31:16]
  input  logic [31:0] s_axis_tdata,
  // command [2:0]
  input  logic [2:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // left_forward [6:0], left_reverse [13:7], right_forward [20:14], right_reverse [27:21],
  // cannon_drive [34:28], buzzer_drive [41:35], bridge_enable [48:42], link_active [49]
  output logic [55:0] m_axis_tdata,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  import dmd_pkg::*;

  localparam int FW = FILTER_FRAC_BITS + 8;

  item_t in_item;
  item_t item;
  logic  item_valid;
  logic  advance;
  logic  out_valid_q;
  logic  out_valid_d;

  logic [8:0]  coef_q;
  logic [15:0] timeout_q;
  logic        watch_en_q;
  logic [6:0]  pwm_max_q;

  logic [TIME_WIDTH-1:0] now_q, now_d;
  logic [TIME_WIDTH-1:0] last_q, last_d;
  logic [TIME_WIDTH-1:0] shot_q, shot_d;
  logic [TIME_WIDTH-1:0] beep_q, beep_d;
  logic [TIME_WIDTH-1:0] elapsed;
  logic [TIME_WIDTH-1:0] deadline;
  logic signed [7:0]     tgt_q [NUM_CH];
  logic signed [7:0]     tgt_d [NUM_CH];
  logic signed [7:0]     tgt_upd [NUM_CH];
  logic signed [FW-1:0]  filt_q [NUM_CH];
  logic signed [FW-1:0]  filt_d [NUM_CH];
  logic signed [FW-1:0]  filt_new [NUM_CH];
  logic [6:0]            pos_lvl [NUM_CH];
  logic [6:0]            neg_lvl [NUM_CH];
  logic [6:0]            lvl_q [NUM_LV];
  logic [6:0]            lvl_d [NUM_LV];
  logic                  link_q, link_d, link_upd;
  logic                  shot_exp, beep_exp;
  logic signed [9:0]     x_w, y_w, mix_a, mix_b;

  assign in_item = '{command:     cmd_e'(s_axis_tuser),
                     speed_or_x:  s_axis_tdata[7:0],
                     joystick_y:  s_axis_tdata[15:8],
                     duration_ms: s_axis_tdata[31:16]};

  dmd_in_reg u_in_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (s_axis_tvalid),
    .ready_o   (s_axis_tready),
    .item_i    (in_item),
    .advance_i (advance),
    .valid_o   (item_valid),
    .item_o    (item)
  );

  assign advance     = item_valid && (!out_valid_q || m_axis_tready);
  assign out_valid_d = advance ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_q);

  for (genvar ch = 0; ch < NUM_CH; ch++) begin : g_iir
    dmd_iir #(
      .FILTER_FRAC_BITS (FILTER_FRAC_BITS)
    ) u_iir (
      .target_i  (tgt_upd[ch]),
      .filt_i    (filt_q[ch]),
      .coef_i    (coef_q),
      .pwm_max_i (pwm_max_q),
      .filt_o    (filt_new[ch]),
      .pos_lvl_o (pos_lvl[ch]),
      .neg_lvl_o (neg_lvl[ch])
    );
  end

  assign elapsed  = now_q - last_q;
  assign link_upd = watch_en_q ? (elapsed <= TIME_WIDTH'(timeout_q)) : link_q;
  assign shot_exp = (shot_q != '0) && (now_q > shot_q);
  assign beep_exp = (beep_q != '0) && (now_q > beep_q);
  assign deadline = now_q + TIME_WIDTH'(item.duration_ms);

  always_comb begin
    for (int ch = 0; ch < NUM_CH; ch++) begin
      tgt_upd[ch] = (watch_en_q && !link_upd) ? 8'sd0 : tgt_q[ch];
    end
    if (shot_exp) begin
      tgt_upd[CH_CANNON] = 8'sd0;
    end
  end

  assign x_w   = 10'(item.speed_or_x);
  assign y_w   = 10'(item.joystick_y);
  assign mix_a = item.joystick_y[7] ? (y_w - x_w) : (y_w + x_w);
  assign mix_b = item.joystick_y[7] ? (y_w + x_w) : (y_w - x_w);

  always_comb begin
    now_d  = now_q;
    last_d = last_q;
    shot_d = shot_q;
    beep_d = beep_q;
    link_d = link_q;
    tgt_d  = tgt_q;
    filt_d = filt_q;
    lvl_d  = lvl_q;
    case (item.command)
      CMD_TICK: begin
        now_d = now_q + TIME_WIDTH'(1);
      end
      CMD_UPDATE: begin
        link_d = link_upd;
        tgt_d  = tgt_upd;
        filt_d = filt_new;
        if (shot_exp) begin
          shot_d = '0;
        end
        if (beep_exp) begin
          beep_d        = '0;
          lvl_d[LV_BUZ] = 7'd0;
        end
        lvl_d[LV_BRIDGE] = (tgt_upd[CH_LEFT] != 8'sd0 || tgt_upd[CH_RIGHT] != 8'sd0 ||
                            tgt_upd[CH_CANNON] != 8'sd0) ? lvl_clamp(LEVEL_FULL, pwm_max_q)
                                                         : 7'd0;
        if (tgt_upd[CH_LEFT] > 8'sd0) begin
          lvl_d[LV_LF] = pos_lvl[CH_LEFT];
          lvl_d[LV_LR] = 7'd0;
        end else begin
          lvl_d[LV_LF] = 7'd0;
          lvl_d[LV_LR] = neg_lvl[CH_LEFT];
        end
        if (tgt_upd[CH_RIGHT] > 8'sd0) begin
          lvl_d[LV_RF] = pos_lvl[CH_RIGHT];
          lvl_d[LV_RR] = 7'd0;
        end else begin
          lvl_d[LV_RF] = 7'd0;
          lvl_d[LV_RR] = neg_lvl[CH_RIGHT];
        end
        lvl_d[LV_CAN] = pos_lvl[CH_CANNON];
      end
      CMD_JOYSTICK: begin
        last_d            = now_q;
        tgt_d[CH_LEFT]    = sat_speed(mix_a);
        tgt_d[CH_RIGHT]   = sat_speed(mix_b);
      end
      CMD_SET_LEFT: begin
        tgt_d[CH_LEFT] = sat_speed(x_w);
      end
      CMD_SET_RIGHT: begin
        tgt_d[CH_RIGHT] = sat_speed(x_w);
      end
      CMD_FIRE: begin
        tgt_d[CH_CANNON] = SPEED_FULL;
        shot_d           = deadline;
      end
      CMD_BEEP: begin
        lvl_d[LV_BUZ] = lvl_clamp(LEVEL_FULL, pwm_max_q);
        beep_d        = deadline;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      now_q       <= '0;
      last_q      <= '0;
      shot_q      <= '0;
      beep_q      <= '0;
      link_q      <= 1'b0;
      out_valid_q <= 1'b0;
      for (int ch = 0; ch < NUM_CH; ch++) begin
        tgt_q[ch]  <= '0;
        filt_q[ch] <= '0;
      end
      for (int lv = 0; lv < NUM_LV; lv++) begin
        lvl_q[lv] <= '0;
      end
    end else begin
      out_valid_q <= out_valid_d;
      if (advance) begin
        now_q  <= now_d;
        last_q <= last_d;
        shot_q <= shot_d;
        beep_q <= beep_d;
        link_q <= link_d;
        tgt_q  <= tgt_d;
        filt_q <= filt_d;
        lvl_q  <= lvl_d;
      end
    end
  end

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q     <= 9'd64;
      timeout_q  <= 16'd500;
      watch_en_q <= 1'b0;
      pwm_max_q  <= 7'd100;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_FILTER_COEF:  coef_q     <= cfg_data_i[8:0];
        CFG_LINK_TIMEOUT: timeout_q  <= cfg_data_i;
        CFG_WATCH_ENABLE: watch_en_q <= cfg_data_i[0];
        CFG_PWM_MAX:      pwm_max_q  <= cfg_data_i[6:0];
        default: begin
        end
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, link_q, lvl_q[LV_BRIDGE], lvl_q[LV_BUZ], lvl_q[LV_CAN],
                          lvl_q[LV_RR], lvl_q[LV_RF], lvl_q[LV_LR], lvl_q[LV_LF]};

`ifndef SYNTH
  a_advance_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> m_axis_tvalid)
    else $error("processed command did not produce a result");

  a_left_one_direction: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(lvl_q[LV_LF] != 7'd0 && lvl_q[LV_LR] != 7'd0))
    else $error("left track driven forward and reverse at once");

  a_cannon_target: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tgt_q[CH_CANNON] == 8'sd0 || tgt_q[CH_CANNON] == SPEED_FULL)
    else $error("cannon target left its two legal values");
`endif

endmodule

### verif/tb_dual_motor_drive_controller.sv
// Self-checking testbench for the dual motor drive controller: predicts every result and compares it.
`timescale 1ns / 1ps

module tb_dual_motor_drive_controller;
  import dmd_pkg::*;

  localparam logic [2:0] CMD_UNUSED = 3'd7;
  localparam int FRAC_BITS = 8;
  localparam int ONE_Q = 1 << FRAC_BITS;
  localparam int DRAIN_CYCLES = 4;
  localparam int HOLD_CYCLES = 400;
  localparam int STALL_LIMIT = 2000;
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 225;

  typedef struct {
    logic [6:0] level [NUM_LV];
    logic       link;
  } drive_outputs_t;

  class drive_predictor;
    logic [8:0]  filter_coef;
    logic [15:0] link_timeout;
    logic        watch_en;
    logic [6:0]  pwm_max;
    logic [31:0] now_ms;
    logic [31:0] last_drive_ms;
    logic [31:0] shot_deadline;
    logic [31:0] beep_deadline;
    int          speed_target [NUM_CH];
    int          speed_filtered [NUM_CH];
    logic        link_ok;
    logic [6:0]  levels [NUM_LV];
    drive_outputs_t expected_outputs [$];
    string       level_names [NUM_LV];
    int          errors;
    int          commands;
    int          updates;
    int          drives;
    int          checked;

    function new();
      filter_coef = 9'd64;
      link_timeout = 16'd500;
      watch_en = 1'b0;
      pwm_max = 7'd100;
      now_ms = '0;
      last_drive_ms = '0;
      shot_deadline = '0;
      beep_deadline = '0;
      link_ok = 1'b0;
      foreach (speed_target[i]) begin
        speed_target[i] = 0;
        speed_filtered[i] = 0;
      end
      foreach (levels[i]) levels[i] = '0;
      level_names = '{"left_forward", "left_reverse", "right_forward", "right_reverse",
                      "cannon_drive", "buzzer_drive", "bridge_enable"};
      errors = 0;
      commands = 0;
      updates = 0;
      drives = 0;
      checked = 0;
    endfunction

    function void write_register(cfg_reg_e idx, logic [15:0] value);
      case (idx)
        CFG_FILTER_COEF:  filter_coef = value[8:0];
        CFG_LINK_TIMEOUT: link_timeout = value;
        CFG_WATCH_ENABLE: watch_en = value[0];
        CFG_PWM_MAX:      pwm_max = value[6:0];
        default: ;
      endcase
    endfunction

    function logic [6:0] pwm_level(int v);
      if (v < 0) return '0;
      if (v > int'(pwm_max)) return pwm_max;
      return 7'(v);
    endfunction

    function int clamp_speed(int v);
      if (v > 100) return 100;
      if (v < -100) return -100;
      return v;
    endfunction

    function int whole_part(int f);
      if (f >= 0) return f >>> FRAC_BITS;
      return -((-f) >>> FRAC_BITS);
    endfunction

    function void apply_update();
      int c;
      int acc;
      logic [31:0] elapsed;
      c = (filter_coef > 9'd256) ? ONE_Q : int'(filter_coef);
      if (watch_en) begin
        elapsed = now_ms - last_drive_ms;
        link_ok = (elapsed > {16'd0, link_timeout}) ? 1'b0 : 1'b1;
        if (!link_ok) foreach (speed_target[i]) speed_target[i] = 0;
      end
      if (shot_deadline != 0 && now_ms > shot_deadline) begin
        speed_target[CH_CANNON] = 0;
        shot_deadline = '0;
      end
      if (beep_deadline != 0 && now_ms > beep_deadline) begin
        levels[LV_BUZ] = '0;
        beep_deadline = '0;
      end
      levels[LV_BRIDGE] = (speed_target[CH_LEFT] != 0 || speed_target[CH_RIGHT] != 0 ||
                           speed_target[CH_CANNON] != 0) ? pwm_level(100) : 7'd0;
      foreach (speed_filtered[i]) begin
        acc = speed_target[i] * ONE_Q * c + speed_filtered[i] * (ONE_Q - c);
        speed_filtered[i] = acc >>> FRAC_BITS;
      end
      if (speed_target[CH_LEFT] > 0) begin
        levels[LV_LF] = pwm_level(whole_part(speed_filtered[CH_LEFT]));
        levels[LV_LR] = '0;
      end else begin
        levels[LV_LF] = '0;
        levels[LV_LR] = pwm_level(-whole_part(speed_filtered[CH_LEFT]));
      end
      if (speed_target[CH_RIGHT] > 0) begin
        levels[LV_RF] = pwm_level(whole_part(speed_filtered[CH_RIGHT]));
        levels[LV_RR] = '0;
      end else begin
        levels[LV_RF] = '0;
        levels[LV_RR] = pwm_level(-whole_part(speed_filtered[CH_RIGHT]));
      end
      levels[LV_CAN] = pwm_level(whole_part(speed_filtered[CH_CANNON]));
    endfunction

    function void note_command(logic [2:0] cmd, logic [31:0] data);
      int sx;
      int jy;
      int sgn;
      logic [15:0] dur;
      drive_outputs_t want;
      sx = int'($signed(data[7:0]));
      jy = int'($signed(data[15:8]));
      dur = data[31:16];
      commands++;
      case (cmd)
        CMD_TICK: now_ms = now_ms + 32'd1;
        CMD_UPDATE: begin
          updates++;
          apply_update();
        end
        CMD_JOYSTICK: begin
          drives++;
          sgn = (jy >= 0) ? 1 : -1;
          last_drive_ms = now_ms;
          speed_target[CH_LEFT] = clamp_speed(jy + sgn * sx);
          speed_target[CH_RIGHT] = clamp_speed(jy - sgn * sx);
        end
        CMD_SET_LEFT: speed_target[CH_LEFT] = clamp_speed(sx);
        CMD_SET_RIGHT: speed_target[CH_RIGHT] = clamp_speed(sx);
        CMD_FIRE: begin
          speed_target[CH_CANNON] = 100;
          shot_deadline = now_ms + {16'd0, dur};
        end
        CMD_BEEP: begin
          levels[LV_BUZ] = pwm_level(100);
          beep_deadline = now_ms + {16'd0, dur};
        end
        default: ;
      endcase
      want.level = levels;
      want.link = link_ok;
      expected_outputs.push_back(want);
    endfunction

    function void check_outputs(logic [55:0] data);
      drive_outputs_t want;
      logic [6:0] got;
      if (expected_outputs.size() == 0) begin
        $error("result transaction with no command pending: %h", data);
        errors++;
        return;
      end
      want = expected_outputs.pop_front();
      checked++;
      for (int i = 0; i < NUM_LV; i++) begin
        got = data[7*i +: 7];
        if (got !== want.level[i]) begin
          $error("%s: expected %0d, actual %0d", level_names[i], want.level[i], got);
          errors++;
        end
      end
      if (data[49] !== want.link) begin
        $error("link_active: expected %0d, actual %0d", want.link, data[49]);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic [2:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;

  drive_predictor predictor;
  bit hold_req = 1'b0;
  bit rx_steady = 1'b0;
  bit tx_steady = 1'b0;
  int quiet_cycles = 0;
  int setting_count = 0;

  dual_motor_drive_controller dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 50);
  endfunction

  // Every transaction on either stream is handled here, command side first.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) predictor.note_command(s_axis_tuser, s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) predictor.check_outputs(m_axis_tdata);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles = quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("FAIL dual_motor_drive_controller");
        $finish;
      end
    end
  end

  initial begin
    int stall;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else if (rx_steady) begin
        m_axis_tready <= 1'b1;
        @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
        stall = gap_len();
        if (stall > 0) begin
          m_axis_tready <= 1'b0;
          repeat (stall) @(posedge clk_i);
        end
      end
    end
  end

  task automatic send_command(input logic [2:0] cmd, input logic [7:0] x, input logic [7:0] y,
                              input logic [15:0] dur);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= cmd;
    s_axis_tdata <= {dur, y, x};
    do @(posedge clk_i); while (!s_axis_tready);
    gap = tx_steady ? 0 : gap_len();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_random_command();
    logic [2:0]  cmd;
    logic [7:0]  x;
    logic [7:0]  y;
    logic [15:0] dur;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 25) cmd = CMD_TICK;
    else if (pick < 45) cmd = CMD_UPDATE;
    else if (pick < 60) cmd = CMD_JOYSTICK;
    else if (pick < 70) cmd = CMD_SET_LEFT;
    else if (pick < 80) cmd = CMD_SET_RIGHT;
    else if (pick < 87) cmd = CMD_FIRE;
    else if (pick < 95) cmd = CMD_BEEP;
    else cmd = CMD_UNUSED;
    x = $urandom_range(0, 1) ? 8'($urandom) : 8'(int'($urandom_range(0, 120)) - 60);
    y = $urandom_range(0, 1) ? 8'($urandom) : 8'(int'($urandom_range(0, 120)) - 60);
    dur = ($urandom_range(0, 4) != 0) ? 16'($urandom_range(0, 40)) : 16'($urandom);
    send_command(cmd, x, y, dur);
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (predictor.expected_outputs.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_settings(input logic [15:0] coef, input logic [15:0] timeout,
                                input logic [15:0] watch, input logic [15:0] pmax);
    logic [15:0] values [4];
    cfg_reg_e idx;
    values = '{coef, timeout, watch, pmax};
    for (int i = 0; i < 4; i++) begin
      idx = cfg_reg_e'(i);
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx;
      cfg_data_i <= values[i];
      do @(posedge clk_i); while (!cfg_ready_o);
      predictor.write_register(idx, values[i]);
    end
    cfg_valid_i <= 1'b0;
    setting_count++;
  endtask

  task automatic run_phase(input int phase);
    logic [15:0] coef;
    logic [15:0] timeout;
    logic [15:0] watch;
    logic [15:0] pmax;
    settle();
    case (phase)
      0: write_settings(16'd0, 16'd0, 16'd1, 16'd0);
      1: write_settings(16'd511, 16'hFFFF, 16'd0, 16'd127);
      2: write_settings(16'd256, 16'd5, 16'd1, 16'd1);
      default: begin
        case ($urandom_range(0, 4))
          0: coef = 16'd1;
          1: coef = 16'd256;
          2: coef = 16'($urandom_range(257, 511));
          default: coef = 16'($urandom_range(0, 256));
        endcase
        timeout = ($urandom_range(0, 3) != 0) ? 16'($urandom_range(0, 40)) : 16'($urandom);
        watch = 16'($urandom_range(0, 1));
        pmax = 16'($urandom_range(0, 127));
        if ($urandom_range(0, 2) == 0) begin
          coef = coef | (16'($urandom) & 16'hFE00);
          watch = watch | (16'($urandom) & 16'hFFFE);
          pmax = pmax | (16'($urandom) & 16'hFF80);
        end
        write_settings(coef, timeout, watch, pmax);
      end
    endcase
    rx_steady = ($urandom_range(0, 3) == 0);
    for (int k = 0; k < PHASE_ITEMS; k++) begin
      if (phase == 3 && k == 0) begin
        hold_req = 1'b1;
        rx_steady = 1'b0;
      end
      tx_steady = (phase == 3 && k < 80) || (phase == 5 && k < 120);
      send_random_command();
    end
    tx_steady = 1'b0;
  endtask

  initial begin
    predictor = new();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_command(CMD_BEEP, 8'd0, 8'd0, 16'd0);
    send_command(CMD_UPDATE, 8'd0, 8'd0, 16'd0);
    send_command(CMD_JOYSTICK, 8'sd127, 8'sd127, 16'd0);
    send_command(CMD_UPDATE, 8'd0, 8'd0, 16'd0);
    send_command(CMD_JOYSTICK, 8'h80, 8'h80, 16'd0);
    send_command(CMD_UPDATE, 8'd0, 8'd0, 16'd0);
    send_command(CMD_SET_LEFT, 8'h80, 8'd0, 16'd0);
    send_command(CMD_SET_RIGHT, 8'sd127, 8'd0, 16'd0);
    send_command(CMD_UPDATE, 8'd0, 8'd0, 16'd0);
    send_command(CMD_FIRE, 8'd0, 8'd0, 16'd2);
    send_command(CMD_BEEP, 8'd0, 8'd0, 16'd1);
    send_command(CMD_TICK, 8'd0, 8'd0, 16'd0);
    send_command(CMD_UPDATE, 8'd0, 8'd0, 16'd0);
    send_command(CMD_TICK, 8'd0, 8'd0, 16'd0);
    send_command(CMD_TICK, 8'd0, 8'd0, 16'd0);
    send_command(CMD_UPDATE, 8'd0, 8'd0, 16'd0);
    send_command(CMD_SET_LEFT, 8'd0, 8'd0, 16'd0);
    send_command(CMD_SET_RIGHT, 8'd0, 8'd0, 16'd0);
    send_command(CMD_UPDATE, 8'd0, 8'd0, 16'd0);
    send_command(CMD_UNUSED, 8'hFF, 8'hFF, 16'hFFFF);
    send_command(CMD_FIRE, 8'd0, 8'd0, 16'hFFFF);
    send_command(CMD_BEEP, 8'd0, 8'd0, 16'hFFFF);
    send_command(CMD_JOYSTICK, 8'd0, 8'hFF, 16'd0);
    send_command(CMD_UPDATE, 8'd0, 8'd0, 16'd0);

    for (int p = 0; p < PHASES; p++) run_phase(p);
    settle();

    $display("Run covered %0d commands, %0d of them updates and %0d joystick drives,",
             predictor.commands, predictor.updates, predictor.drives);
    $display("over %0d register settings with random stalls; %0d results compared.",
             setting_count, predictor.checked);
    if (predictor.errors == 0) begin
      $display("PASS dual_motor_drive_controller");
    end else begin
      $display("FAIL dual_motor_drive_controller");
    end
    $finish;
  end

endmodule

### sim.f
hdl/dmd_pkg.sv
hdl/dmd_in_reg.sv
hdl/dmd_iir.sv
hdl/dual_motor_drive_controller.sv
verif/tb_dual_motor_drive_controller.sv
